// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lrf assertion failed");

// next-cycle implication
`define LRF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lrf assertion failed");

`endif

// File: hw/rtl/lrf_pkg.sv
package lrf_pkg;

	localparam int DISPLAY_WIDTH  = 256;
	localparam int DISPLAY_HEIGHT = 128;
	localparam int ROW_BYTES      = 16;
	localparam int COORD_BITS     = 12;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	localparam logic [7:0] MASK_MSB = 8'h80;

	typedef logic signed [COORD_BITS-1:0] coord_t;

endpackage

// File: hw/rtl/line_rasterizer_framebuffer.sv
// A pixel word appears on the pix channel in the cycle after its command is accepted.
// Throughput: one command word per cycle, but none while a pixel word is stalled; a new
// word is taken in the cycle the held pixel leaves. A step command while no line
// is active is consumed and gives no pixel word. Reset (arst_n low, asynchronous)
// clears all line state and the output valid; the block starts idle.
module line_rasterizer_framebuffer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  logic            operation,
	input  lrf_pkg::coord_t x_start,
	input  lrf_pkg::coord_t y_start,
	input  lrf_pkg::coord_t x_end,
	input  lrf_pkg::coord_t y_end,
	input  logic            color,
	output logic            pix_valid,
	input  logic            pix_stall,
	output lrf_pkg::coord_t pixel_x,
	output lrf_pkg::coord_t pixel_y,
	output logic [11:0]     byte_offset,
	output logic [7:0]      bit_mask,
	output logic            pixel_color,
	output logic            visible,
	output logic            last
);
	import lrf_pkg::*;

	coord_t             cur_x_q, cur_y_q, end_x_q, end_y_q;
	logic signed [12:0] delta_x_q, neg_delta_y_q;
	logic               step_x_neg_q, step_y_neg_q;
	logic signed [14:0] error_term_q;
	logic               line_color_q, active_q;

	coord_t             nx, ny, nex, ney;
	logic signed [12:0] ndx, nndy, dxs, dys;
	logic               nsxn, nsyn, ncol;
	logic signed [14:0] nerr;
	logic signed [15:0] e2;
	logic               do_x, do_y, take, emit;
	logic               vis, fin;
	logic [23:0]        off_w;

	logic               pix_valid_q;
	coord_t             pixel_x_q, pixel_y_q;
	logic [11:0]        byte_offset_q;
	logic [7:0]         bit_mask_q;
	logic               pixel_color_q, visible_q, last_q;

	assign cmd_stall = pix_valid_q && pix_stall;
	assign take      = cmd_valid && !cmd_stall;

	always_comb begin
		nx   = cur_x_q;
		ny   = cur_y_q;
		nex  = end_x_q;
		ney  = end_y_q;
		ndx  = delta_x_q;
		nndy = neg_delta_y_q;
		nsxn = step_x_neg_q;
		nsyn = step_y_neg_q;
		nerr = error_term_q;
		ncol = line_color_q;
		emit = 1'b0;
		dxs  = 13'(x_end) - 13'(x_start);
		dys  = 13'(y_end) - 13'(y_start);
		e2   = {error_term_q[14], error_term_q[14:0]} <<< 1;
		do_x = e2 >= 16'(neg_delta_y_q);
		do_y = e2 <= 16'(delta_x_q);
		if (operation == OP_START) begin
			nx   = x_start;
			ny   = y_start;
			nex  = x_end;
			ney  = y_end;
			ndx  = dxs[12] ? -dxs : dxs;
			nndy = dys[12] ? dys : -dys;
			nsxn = !(x_start < x_end);
			nsyn = !(y_start < y_end);
			nerr = 15'(ndx) + 15'(nndy);
			ncol = color;
			emit = 1'b1;
		end else if (operation == OP_STEP && active_q) begin
			nerr = error_term_q + (do_x ? 15'(neg_delta_y_q) : 15'sd0)
				+ (do_y ? 15'(delta_x_q) : 15'sd0);
			if (do_x) begin
				nx = cur_x_q + {{(COORD_BITS-1){step_x_neg_q}}, 1'b1};
			end
			if (do_y) begin
				ny = cur_y_q + {{(COORD_BITS-1){step_y_neg_q}}, 1'b1};
			end
			emit = 1'b1;
		end
		vis = !nx[COORD_BITS-1] && ({1'b0, nx} < (COORD_BITS+1)'(DISPLAY_WIDTH))
			&& !ny[COORD_BITS-1] && ({1'b0, ny} < (COORD_BITS+1)'(DISPLAY_HEIGHT));
		off_w = 24'($unsigned(nx)) * 24'(ROW_BYTES) + 24'($unsigned(ny) >> 3);
		fin   = (nx == nex) && (ny == ney);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			end_x_q       <= '0;
			end_y_q       <= '0;
			delta_x_q     <= '0;
			neg_delta_y_q <= '0;
			step_x_neg_q  <= 1'b0;
			step_y_neg_q  <= 1'b0;
			error_term_q  <= '0;
			line_color_q  <= 1'b0;
			active_q      <= 1'b0;
			pix_valid_q   <= 1'b0;
		end else begin
			if (take && emit) begin
				cur_x_q       <= nx;
				cur_y_q       <= ny;
				end_x_q       <= nex;
				end_y_q       <= ney;
				delta_x_q     <= ndx;
				neg_delta_y_q <= nndy;
				step_x_neg_q  <= nsxn;
				step_y_neg_q  <= nsyn;
				error_term_q  <= nerr;
				line_color_q  <= ncol;
				active_q      <= !fin;
				pix_valid_q   <= 1'b1;
			end else if (!pix_stall) begin
				pix_valid_q   <= 1'b0;
			end
		end
	end

	// hold the pixel word while stalled
	always_ff @(posedge clk) begin
		if (take && emit) begin
			pixel_x_q     <= nx;
			pixel_y_q     <= ny;
			byte_offset_q <= vis ? off_w[11:0] : 12'd0;
			bit_mask_q    <= vis ? (MASK_MSB >> ny[2:0]) : 8'd0;
			pixel_color_q <= ncol;
			visible_q     <= vis;
			last_q        <= fin;
		end
	end

	assign pix_valid   = pix_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign byte_offset = byte_offset_q;
	assign bit_mask    = bit_mask_q;
	assign pixel_color = pixel_color_q;
	assign visible     = visible_q;
	assign last        = last_q;

endmodule

// File: hw/rtl/lrf_checker.sv
`include "assert_macros.svh"

module lrf_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            cmd_valid,
	input logic            cmd_stall,
	input logic            operation,
	input logic            pix_valid,
	input logic            pix_stall,
	input lrf_pkg::coord_t pixel_x,
	input lrf_pkg::coord_t pixel_y,
	input logic [11:0]     byte_offset,
	input logic [7:0]      bit_mask,
	input logic            pixel_color,
	input logic            visible,
	input logic            last
);
	import lrf_pkg::*;

	logic        start_take;
	logic        held;
	logic        blank_w;
	logic [46:0] word_w;

	assign start_take = cmd_valid && !cmd_stall && operation == OP_START;
	assign held       = pix_valid && pix_stall;
	assign blank_w    = (byte_offset == 12'd0) && (bit_mask == 8'd0);
	assign word_w     = {pixel_x, pixel_y, byte_offset, bit_mask, pixel_color, visible, last};

	`LRF_ASSERT_NXT(a_start_gives_word, clk, arst_n, start_take, pix_valid)
	`LRF_ASSERT_IMP(a_hidden_no_write, clk, arst_n, pix_valid && !visible, blank_w)
	`LRF_ASSERT_IMP(a_mask_onehot, clk, arst_n, pix_valid && visible, $onehot(bit_mask))
	`LRF_ASSERT_NXT(a_valid_holds, clk, arst_n, held, pix_valid)
	`LRF_ASSERT_NXT(a_word_holds, clk, arst_n, held, $stable(word_w))

endmodule

bind line_rasterizer_framebuffer lrf_checker u_lrf_checker (.*);

// File: tb/line_rasterizer_framebuffer_test.sv
`timescale 1ns / 100ps

module line_rasterizer_framebuffer_test;
	import lrf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PIXELS = 800;

	typedef struct {
		coord_t x;
		coord_t y;
		logic [11:0] offset;
		logic [7:0] mask;
		logic ink;
		logic vis;
		logic fin;
	} pixel_t;

	typedef struct {
		logic op;
		coord_t xs;
		coord_t ys;
		coord_t xe;
		coord_t ye;
		logic col;
		bit typed;
		pixel_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	logic operation;
	coord_t x_start;
	coord_t y_start;
	coord_t x_end;
	coord_t y_end;
	logic color;
	logic pix_valid;
	logic pix_stall;
	coord_t pixel_x;
	coord_t pixel_y;
	logic [11:0] byte_offset;
	logic [7:0] bit_mask;
	logic pixel_color;
	logic visible;
	logic last;

	int pen_x = 0, pen_y = 0, goal_x = 0, goal_y = 0;
	int span_x = 0, span_y_neg = 0, err_acc = 0;
	bit walk_x_neg = 0, walk_y_neg = 0, ink = 0, drawing = 0;

	pixel_t pending_pixels[$];
	plan_row_t directed_plan[$];
	int fault_count = 0;
	int cycle_count = 0;
	int pixels_drawn = 0;
	bit gap_free = 0;

	line_rasterizer_framebuffer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.operation(operation),
		.x_start(x_start),
		.y_start(y_start),
		.x_end(x_end),
		.y_end(y_end),
		.color(color),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.byte_offset(byte_offset),
		.bit_mask(bit_mask),
		.pixel_color(pixel_color),
		.visible(visible),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic pixel_t plot();
		pixel_t p;
		bit vis;
		vis = pen_x >= 0 && pen_x < DISPLAY_WIDTH && pen_y >= 0 && pen_y < DISPLAY_HEIGHT;
		p.x = coord_t'(pen_x);
		p.y = coord_t'(pen_y);
		p.offset = vis ? 12'(pen_x * ROW_BYTES + pen_y / 8) : 12'd0;
		p.mask = vis ? MASK_MSB >> (pen_y % 8) : 8'd0;
		p.ink = ink;
		p.vis = vis;
		p.fin = pen_x == goal_x && pen_y == goal_y;
		drawing = !p.fin;
		return p;
	endfunction

	task automatic rasterize(input logic op, input coord_t xs, input coord_t ys,
			input coord_t xe, input coord_t ye, input logic col,
			output bit made, output pixel_t p);
		int e2;
		made = 1'b0;
		if (op == OP_START) begin
			pen_x = xs;
			pen_y = ys;
			goal_x = xe;
			goal_y = ye;
			span_x = goal_x >= pen_x ? goal_x - pen_x : pen_x - goal_x;
			span_y_neg = -(goal_y >= pen_y ? goal_y - pen_y : pen_y - goal_y);
			walk_x_neg = !(pen_x < goal_x);
			walk_y_neg = !(pen_y < goal_y);
			err_acc = span_x + span_y_neg;
			ink = col;
			p = plot();
			made = 1'b1;
		end else if (drawing) begin
			e2 = 2 * err_acc;
			if (e2 >= span_y_neg) begin
				err_acc += span_y_neg;
				pen_x += walk_x_neg ? -1 : 1;
			end
			if (e2 <= span_x) begin
				err_acc += span_x;
				pen_y += walk_y_neg ? -1 : 1;
			end
			p = plot();
			made = 1'b1;
		end
	endtask

	function automatic void plan_row(logic op, int xs, int ys, int xe, int ye, logic col,
			bit typed = 0, int px = 0, int py = 0, int off = 0, int msk = 0,
			bit vis = 0, bit fin = 0);
		plan_row_t r;
		r.op = op;
		r.xs = coord_t'(xs);
		r.ys = coord_t'(ys);
		r.xe = coord_t'(xe);
		r.ye = coord_t'(ye);
		r.col = col;
		r.typed = typed;
		r.want.x = coord_t'(px);
		r.want.y = coord_t'(py);
		r.want.offset = 12'(off);
		r.want.mask = 8'(msk);
		r.want.ink = col;
		r.want.vis = vis;
		r.want.fin = fin;
		directed_plan.push_back(r);
	endfunction

	task automatic issue_word(input logic op, input coord_t xs, input coord_t ys,
			input coord_t xe, input coord_t ye, input logic col,
			input bit typed, input pixel_t want);
		pixel_t p;
		bit made;
		int pick;
		int gap;
		cmd_valid <= 1'b1;
		operation <= op;
		x_start <= xs;
		y_start <= ys;
		x_end <= xe;
		y_end <= ye;
		color <= col;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		rasterize(op, xs, ys, xe, ye, col, made, p);
		if (made) begin
			pending_pixels.push_back(typed ? want : p);
			pixels_drawn++;
		end
		gap = 0;
		if (!gap_free) begin
			pick = $urandom_range(0, 19);
			if (pick >= 18)
				gap = $urandom_range(8, 30);
			else if (pick >= 12)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_pixels.size() != 0);
	endtask

	function automatic void check_field(string name, integer want, integer got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fault_count++;
		end
	endfunction

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && pix_valid && !pix_stall) begin
			if (pending_pixels.size() == 0) begin
				$error("pixel word with none expected: x %0d y %0d", pixel_x, pixel_y);
				fault_count++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("pixel_x", want.x, pixel_x);
				check_field("pixel_y", want.y, pixel_y);
				check_field("byte_offset", want.offset, byte_offset);
				check_field("bit_mask", want.mask, bit_mask);
				check_field("pixel_color", want.ink, pixel_color);
				check_field("visible", want.vis, visible);
				check_field("last", want.fin, last);
			end
		end
	end

	initial begin
		int episode;
		int pick;
		pix_stall <= 1'b0;
		episode = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			episode++;
			pick = $urandom_range(0, 19);
			if (episode == 4 || pick == 0) begin
				pix_stall <= 1'b1;
				repeat ($urandom_range(40, 120)) @(posedge clk);
			end else if (pick < 6) begin
				pix_stall <= 1'b0;
				repeat ($urandom_range(10, 50)) @(posedge clk);
			end else begin
				repeat ($urandom_range(10, 40)) begin
					pix_stall <= ($urandom_range(0, 3) == 0);
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		plan_row_t r;
		pixel_t none;
		int corners[4] = '{-2048, -1, 0, 2047};
		int kind;
		int budget;
		int xs, ys, xe, ye;
		logic col;

		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		operation <= OP_START;
		x_start <= '0;
		y_start <= '0;
		x_end <= '0;
		y_end <= '0;
		color <= 1'b0;
		none = '{default: '0};

		plan_row(OP_STEP, 5, 5, 9, 9, 1'b1);
		plan_row(OP_START, 0, 0, 0, 0, 1'b0, 1, 0, 0, 0, 'h80, 1, 1);
		plan_row(OP_START, 255, 127, 255, 127, 1'b1, 1, 255, 127, 'hFFF, 'h01, 1, 1);
		plan_row(OP_START, -2048, -2048, -2048, -2048, 1'b0, 1, -2048, -2048, 0, 0, 0, 1);
		plan_row(OP_START, 2047, 2047, 2047, 2047, 1'b1, 1, 2047, 2047, 0, 0, 0, 1);
		plan_row(OP_STEP, 0, 0, 0, 0, 1'b0);
		plan_row(OP_START, 256, 0, 256, 0, 1'b0, 1, 256, 0, 0, 0, 0, 1);
		plan_row(OP_START, 0, 128, 0, 128, 1'b1, 1, 0, 128, 0, 0, 0, 1);
		plan_row(OP_START, -1, -1, 2, 3, 1'b0, 1, -1, -1, 0, 0, 0, 0);
		repeat (4) plan_row(OP_STEP, 0, 0, 0, 0, 1'b0);
		plan_row(OP_START, 10, 10, 4, 7, 1'b1);
		repeat (2) plan_row(OP_STEP, 0, 0, 0, 0, 1'b0);
		plan_row(OP_START, 100, 60, 108, 60, 1'b0);
		plan_row(OP_STEP, 0, 0, 0, 0, 1'b1);
		plan_row(OP_START, 7, 0, 7, 9, 1'b0);
		repeat (3) plan_row(OP_STEP, 0, 0, 0, 0, 1'b0);
		plan_row(OP_START, 2047, -2048, -2048, 2047, 1'b1, 1, 2047, -2048, 0, 0, 0, 0);
		plan_row(OP_STEP, 0, 0, 0, 0, 1'b0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			r = directed_plan[i];
			issue_word(r.op, r.xs, r.ys, r.xe, r.ye, r.col, r.typed, r.want);
		end
		settle();

		pixels_drawn = 0;
		while (pixels_drawn < RANDOM_PIXELS) begin
			if ($urandom_range(0, 24) == 0)
				settle();
			gap_free = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				xs = $urandom_range(0, 279) - 12;
				ys = $urandom_range(0, 151) - 12;
				xe = xs + $urandom_range(0, 24) - 12;
				ye = ys + $urandom_range(0, 24) - 12;
				budget = 64;
			end else if (kind < 9) begin
				xs = $urandom_range(0, 4095) - 2048;
				ys = $urandom_range(0, 4095) - 2048;
				xe = $urandom_range(0, 4095) - 2048;
				ye = $urandom_range(0, 4095) - 2048;
				budget = $urandom_range(0, 30);
			end else begin
				xs = corners[$urandom_range(0, 3)];
				ys = corners[$urandom_range(0, 3)];
				xe = corners[$urandom_range(0, 3)];
				ye = corners[$urandom_range(0, 3)];
				budget = $urandom_range(0, 10);
			end
			if ($urandom_range(0, 5) == 0)
				budget = $urandom_range(0, 6);
			col = $urandom_range(0, 1);
			issue_word(OP_START, coord_t'(xs), coord_t'(ys), coord_t'(xe), coord_t'(ye),
				col, 0, none);
			while (drawing && budget > 0) begin
				issue_word(OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), $urandom_range(0, 1), 0, none);
				budget--;
			end
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 2))
					issue_word(OP_STEP, coord_t'($urandom), coord_t'($urandom),
						coord_t'($urandom), coord_t'($urandom), $urandom_range(0, 1), 0, none);
		end
		settle();
		repeat (8) @(posedge clk);

		if (fault_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
